// ===== src/ucafd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucafd_pkg
// Shared types and constants of the USB-CAN analyzer frame decoder.
// ----------------------------------------------------------------------------
package ucafd_pkg;

   // Window geometry and framing bytes.
   localparam int unsigned WinDepth = 20;
   localparam int unsigned WinAddrW = 5;
   localparam logic [7:0]  MarkStart = 8'hAA;
   localparam logic [7:0]  MarkEnd   = 8'h55;
   localparam logic [7:0]  TypeBase  = 8'hC0;
   localparam logic [7:0]  TypeExt   = 8'h20;
   localparam logic [7:0]  TypeRtr   = 8'h10;
   localparam logic [7:0]  TypeLen   = 8'h0F;
   localparam logic [3:0]  MaxDlc    = 4'd8;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK,
      ST_TYPE,
      ST_CHECK,
      ST_GATHER,
      ST_EMIT,
      ST_DONE
   } state_type;

   // One decoded CAN frame.
   typedef struct packed {
      logic [31:0] can_id;
      logic        is_extended;
      logic        is_remote;
      logic [3:0]  data_len;
      logic [63:0] payload;
   } frame_type;

   // Write request from the sequencer to the byte window.
   typedef struct packed {
      logic       we;
      logic [7:0] data;
   } win_wr_type;

endpackage

// ===== src/ucafd_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucafd_addr
// Shared address unit: maps a window offset onto the circular byte buffer.
// ----------------------------------------------------------------------------
module ucafd_addr (
   input  logic [ucafd_pkg::WinAddrW-1:0] base,
   input  logic [ucafd_pkg::WinAddrW-1:0] offset,
   output logic [ucafd_pkg::WinAddrW-1:0] addr
);
   import ucafd_pkg::*;

   logic [WinAddrW:0] sum;

   // Add and wrap once; base is below the depth and offsets stay in range.
   always_comb begin
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (WinAddrW + 1)'(WinDepth)) begin
         sum = sum - (WinAddrW + 1)'(WinDepth);
      end
      addr = sum[WinAddrW-1:0];
   end

endmodule

// ===== src/ucafd_win.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucafd_win
// Circular byte window: one write and one read per cycle through a single shared address.
// ----------------------------------------------------------------------------
module ucafd_win (
   input  logic                           clock,
   input  ucafd_pkg::win_wr_type          wr,
   input  logic [ucafd_pkg::WinAddrW-1:0] addr,
   output logic [7:0]                     rdata
);
   import ucafd_pkg::*;

   logic [7:0] bytes_ff [WinDepth];

   // Store a received byte; entries hold no reset value.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         bytes_ff[addr] <= wr.data;
      end
   end

   // Single read port; out-of-range addresses read as zero.
   assign rdata = (addr < WinAddrW'(WinDepth)) ? bytes_ff[addr] : 8'h00;

endmodule

// ===== src/ucafd_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucafd_seq
// Scan sequencer: walks the byte window one read per cycle unless a frame waits on
// a full output register, decodes packets and hands finished frames to a one-entry output register.
// ----------------------------------------------------------------------------
module ucafd_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_byte,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output ucafd_pkg::frame_type           rsp_frame,
   output logic                           rsp_last,
   output ucafd_pkg::win_wr_type          win_wr,
   output logic [ucafd_pkg::WinAddrW-1:0] base,
   output logic [ucafd_pkg::WinAddrW-1:0] offset,
   input  logic [ucafd_pkg::WinAddrW-1:0] addr,
   input  logic [7:0]                     rdata
);
   import ucafd_pkg::*;

   state_type             state_ff, state_in;
   logic [WinAddrW-1:0]   base_ff, base_in;
   logic [WinAddrW-1:0]   count_ff, count_in;
   logic [WinAddrW-1:0]   end_ff, end_in;
   logic [WinAddrW-1:0]   idx_ff, idx_in;
   logic                  ext_ff, ext_in;
   logic                  rtr_ff, rtr_in;
   logic [3:0]            dlc_ff, dlc_in;
   logic [3:0]            total_ff, total_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic [31:0]           id_ff, id_in;
   logic [63:0]           pay_ff, pay_in;
   logic [1:0]            nres_ff, nres_in;
   frame_type             pend_ff, pend_in;
   frame_type             out_ff, out_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_valid_ff, out_valid_in;

   logic [WinAddrW-1:0]   start_count;
   logic [WinAddrW-1:0]   avail;
   logic [3:0]            t_dlc;
   logic                  t_ext;
   logic [3:0]            t_total;
   logic [3:0]            idlen;
   logic [3:0]            pay_pos;
   logic                  slot_free;
   frame_type             frame;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         count_ff     <= '0;
         nres_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         nres_ff      <= nres_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      end_ff      <= end_in;
      idx_ff      <= idx_in;
      ext_ff      <= ext_in;
      rtr_ff      <= rtr_in;
      dlc_ff      <= dlc_in;
      total_ff    <= total_in;
      cnt_ff      <= cnt_in;
      id_ff       <= id_in;
      pay_ff      <= pay_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   // Decode helpers for the current window byte and frame under assembly.
   always_comb begin
      start_count = (count_ff >= WinAddrW'(WinDepth)) ? '0 : count_ff;
      avail       = end_ff - idx_ff;
      t_dlc       = rdata[3:0] & TypeLen[3:0];
      t_ext       = (rdata & TypeExt) != 8'h00;
      t_total     = 4'd3 + (t_ext ? 4'd4 : 4'd2) + t_dlc;
      idlen       = ext_ff ? 4'd4 : 4'd2;
      pay_pos     = cnt_ff - idlen;
      slot_free   = !out_valid_ff || rsp_tready;
      frame.can_id      = id_ff;
      frame.is_extended = ext_ff;
      frame.is_remote   = rtr_ff;
      frame.data_len    = dlc_ff;
      frame.payload     = pay_ff;
   end

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      ext_in       = ext_ff;
      rtr_in       = rtr_ff;
      dlc_in       = dlc_ff;
      total_in     = total_ff;
      cnt_in       = cnt_ff;
      id_in        = id_ff;
      pay_in       = pay_ff;
      nres_in      = nres_ff;
      pend_in      = pend_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      win_wr.we    = 1'b0;
      win_wr.data  = req_byte;
      offset       = idx_ff;
      req_tready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Append the new byte behind the buffered ones.
            req_tready = 1'b1;
            offset     = start_count;
            if (req_tvalid) begin
               win_wr.we = 1'b1;
               end_in    = start_count + WinAddrW'(1);
               idx_in    = '0;
               state_in  = ST_SEEK;
            end
         end
         ST_SEEK: begin
            // Skip bytes until a start byte is under the read pointer.
            offset = idx_ff;
            if (idx_ff >= end_ff) begin
               state_in = ST_DONE;
            end else if (rdata != MarkStart) begin
               idx_in = idx_ff + WinAddrW'(1);
            end else if (avail < WinAddrW'(2)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_TYPE;
            end
         end
         ST_TYPE: begin
            // Classify the type byte that follows the start byte.
            offset = idx_ff + WinAddrW'(1);
            if (rdata == MarkEnd) begin
               if (avail < WinAddrW'(WinDepth)) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + WinAddrW'(WinDepth);
                  state_in = ST_SEEK;
               end
            end else if ((rdata & TypeBase) != TypeBase || t_dlc > MaxDlc) begin
               idx_in   = idx_ff + WinAddrW'(1);
               state_in = ST_SEEK;
            end else if (avail < WinAddrW'(t_total)) begin
               state_in = ST_DONE;
            end else begin
               ext_in   = t_ext;
               rtr_in   = (rdata & TypeRtr) != 8'h00;
               dlc_in   = t_dlc;
               total_in = t_total;
               cnt_in   = '0;
               id_in    = '0;
               pay_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // The packet must close with the end byte.
            offset = idx_ff + WinAddrW'(total_ff) - WinAddrW'(1);
            if (rdata != MarkEnd) begin
               idx_in   = idx_ff + WinAddrW'(1);
               state_in = ST_SEEK;
            end else begin
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            // Shift identifier and payload bytes in, least significant first.
            offset = idx_ff + WinAddrW'(2) + WinAddrW'(cnt_ff);
            if (cnt_ff < idlen) begin
               id_in[8*cnt_ff[1:0] +: 8] = rdata;
            end else begin
               pay_in[8*pay_pos[2:0] +: 8] = rdata;
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == idlen + dlc_ff - 4'd1) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hold the newest frame back so the final one can carry last.
            if (nres_ff == 2'd0) begin
               pend_in  = frame;
               nres_in  = 2'd1;
               idx_in   = idx_ff + WinAddrW'(total_ff);
               state_in = ST_SEEK;
            end else if (nres_ff == 2'd1) begin
               if (slot_free) begin
                  out_in       = pend_ff;
                  out_last_in  = 1'b0;
                  out_valid_in = 1'b1;
                  pend_in      = frame;
                  nres_in      = 2'd2;
                  idx_in       = idx_ff + WinAddrW'(total_ff);
                  state_in     = ST_SEEK;
               end
            end else begin
               idx_in   = idx_ff + WinAddrW'(total_ff);
               state_in = ST_SEEK;
            end
         end
         ST_DONE: begin
            // Drop consumed bytes by moving the base; flush the held frame.
            offset = idx_ff;
            if (nres_ff == 2'd0 || slot_free) begin
               if (nres_ff != 2'd0) begin
                  out_in       = pend_ff;
                  out_last_in  = 1'b1;
                  out_valid_in = 1'b1;
               end
               base_in  = addr;
               count_in = (idx_ff >= end_ff) ? '0 : end_ff - idx_ff;
               nres_in  = 2'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign base       = base_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_frame  = out_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ===== src/usb_can_analyzer_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_can_analyzer_frame_decoder_unit
// Decodes the analyzer's serial byte stream into CAN frames.
//
//   Channel  Direction  Carries
//   req_*    in         one received serial byte per transaction
//   rsp_*    out        one decoded CAN frame per transaction, tlast on the
//                       final frame caused by a byte
//
// A byte is taken only in the idle state and is written into the window. The
// scan then looks at window bytes in turn for a start byte until it runs off the
// end, reads each type byte, checks each closing byte, gathers identifier and
// payload bytes and emits each decoded frame, then closes in the done state.
// A frame that meets a full output register holds the scan until it is taken.
// Reset is synchronous and empties the window; its bytes are not cleared.
// ----------------------------------------------------------------------------
module usb_can_analyzer_frame_decoder_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [31:0] can_id, [35:32] data_len,
                                     // [99:36] payload, [103:100] zero
   output logic [1:0]   rsp_tuser,   // [0] is_extended, [1] is_remote
   output logic         rsp_tlast
);
   import ucafd_pkg::*;

   win_wr_type          win_wr;
   logic [WinAddrW-1:0] base;
   logic [WinAddrW-1:0] offset;
   logic [WinAddrW-1:0] addr;
   logic [7:0]          rdata;
   frame_type           frame;

   // Shared address unit.
   ucafd_addr u_addr (
      .base   (base),
      .offset (offset),
      .addr   (addr)
   );

   // Byte window.
   ucafd_win u_win (
      .clock (clock),
      .wr    (win_wr),
      .addr  (addr),
      .rdata (rdata)
   );

   // Scan sequencer and output register.
   ucafd_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_frame  (frame),
      .rsp_last   (rsp_tlast),
      .win_wr     (win_wr),
      .base       (base),
      .offset     (offset),
      .addr       (addr),
      .rdata      (rdata)
   );

   // Pack the frame onto the result channel.
   assign rsp_tdata = {4'b0000, frame.payload, frame.data_len, frame.can_id};
   assign rsp_tuser = {frame.is_remote, frame.is_extended};

endmodule

// ===== src/ucafd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucafd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ucafd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // In the cycle after a byte transaction the scan keeps the input closed.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a byte transaction");

   // Payload length never exceeds eight bytes.
   a_dlc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:32] <= 4'd8)
      else $error("data length above eight");

   // A standard frame carries a two-byte identifier.
   a_std_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:16] == 16'h0000)
      else $error("standard identifier has upper bits set");

   // A frame without payload has an all-zero payload field.
   a_empty_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35:32] == 4'd0 |-> rsp_tdata[99:36] == 64'h0)
      else $error("empty frame carries payload bits");

endmodule

bind usb_can_analyzer_frame_decoder_unit ucafd_checker u_ucafd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
